/* design/ptu_pkg.sv */
package ptu_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  // Field widths of the line-length division.
  localparam int NUM_W = 24;
  localparam int DEN_W = 14;
  localparam int Q_W   = 10;

  typedef enum logic [1:0] {
    CMD_CREATE = 2'd0,
    CMD_TICK   = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  localparam logic [1:0] KIND_LINE = 2'd3;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TK_RD,
    ST_TK_MOD,
    ST_RP_RD,
    ST_RP_MUL,
    ST_RP_START,
    ST_RP_DIV,
    ST_RP_OUT
  } state_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] pos_y;
    logic [15:0] pos_x;
    logic [15:0] vel_y;
    logic [15:0] vel_x;
    logic [7:0]  start;
    logic [7:0]  life;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

  // Signed 16-bit add that clamps to the representable range.
  function automatic logic [15:0] sat_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {a[15], a} + {b[15], b};
    if (s[16] != s[15]) begin
      sat_add = s[16] ? 16'h8000 : 16'h7FFF;
    end else begin
      sat_add = s[15:0];
    end
  endfunction

  // Q8.8 to whole pixels, truncated toward zero.
  function automatic logic [7:0] to_pixel(input logic [15:0] p);
    logic [7:0] h;
    h = p[15:8];
    if (p[15] && (p[7:0] != 8'd0)) begin
      h = h + 8'd1;
    end
    to_pixel = h;
  endfunction

  // Magnitude of a signed 16-bit value; the most negative value fits unsigned.
  function automatic logic [15:0] mag16(input logic [15:0] v);
    mag16 = v[15] ? (16'd0 - v) : v;
  endfunction

endpackage

/* design/ptu_if.sv */
interface ptu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [1:0]  ptype;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic [7:0]  life;

  modport source (output valid, cmd, ptype, pos_x, pos_y, vel_x, vel_y, life, input ready);
  modport sink (input valid, cmd, ptype, pos_x, pos_y, vel_x, vel_y, life, output ready);
endinterface

interface ptu_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic signed [7:0] pixel_x;
  logic signed [7:0] pixel_y;
  logic signed [9:0] line_dx;
  logic signed [9:0] line_dy;
  logic       last;

  modport source (output valid, kind, pixel_x, pixel_y, line_dx, line_dy, last, input ready);
  modport sink (input valid, kind, pixel_x, pixel_y, line_dx, line_dy, last, output ready);
endinterface

/* design/ptu_ram.sv */
module ptu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/ptu_div.sv */
module ptu_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [ptu_pkg::NUM_W-1:0] num,
  input  logic [ptu_pkg::DEN_W-1:0] den,
  output logic [ptu_pkg::Q_W-1:0]   quot,
  output logic                      done
);

  import ptu_pkg::*;

  logic [NUM_W-1:0]      rem;
  logic [NUM_W-1:0]      dsh;
  logic [$clog2(Q_W)-1:0] step;
  logic                  busy;

  // Restoring division, one quotient bit per cycle from the top bit down.
  // The quotient is known to stay below 2**Q_W.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        rem  <= num;
        dsh  <= NUM_W'({den, {(Q_W-1){1'b0}}});
        step <= ($clog2(Q_W))'(Q_W - 1);
        quot <= '0;
      end else if (busy) begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          quot[step] <= 1'b1;
        end
        dsh <= dsh >> 1;
        if (step == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 1'b1;
        end
      end
    end
  end

endmodule

/* design/particle_table_update.sv */
// Channel | Dir | Transfer carries
// items   | in  | cmd, ptype, pos_x, pos_y, vel_x, vel_y, life
// results | out | kind, pixel_x, pixel_y, line_dx, line_dy, last (one per survivor)
//
// Create and clear are done in the idle state. A tick reads every live entry in
// a compaction pass through the table RAM, then reports each survivor, waiting
// on the 10-step serial divider for the line length.
// Reset empties the table at once; no clearing pass. Items are taken only while
// idle; a stalled result holds the report pass.
module particle_table_update #(
  parameter int TABLE_DEPTH = ptu_pkg::TABLE_DEPTH_DEF
) (
  input logic clk,
  input logic rst,
  ptu_in_if.sink    items,
  ptu_out_if.source results
);

  import ptu_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  state_t state, state_next;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic [CW-1:0] wr_idx;

  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [AW-1:0] ram_raddr;
  rec_t          ram_wdata;
  rec_t          ram_rdata;
  rec_t          upd;

  logic [NUM_W-1:0] prod_x, prod_y;
  logic [DEN_W-1:0] den;
  logic             neg_x, neg_y;
  logic [1:0]       out_kind;
  logic [7:0]       out_px, out_py;
  logic [9:0]       out_dx, out_dy;
  logic [Q_W-1:0]   q_x, q_y;
  logic             done_x, done_y;
  logic             div_done;
  logic             div_start;

  ptu_ram #(.WIDTH(REC_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  ptu_div u_div_x (
    .clk (clk), .rst (rst), .start (div_start),
    .num (prod_x), .den (den), .quot (q_x), .done (done_x)
  );

  ptu_div u_div_y (
    .clk (clk), .rst (rst), .start (div_start),
    .num (prod_y), .den (den), .quot (q_y), .done (done_y)
  );

  // Both dividers run in lockstep and finish together.
  assign div_done = done_x & done_y;

  // Moved and aged copy of the entry just read.
  always_comb begin
    upd       = ram_rdata;
    upd.pos_x = sat_add(ram_rdata.pos_x, ram_rdata.vel_x);
    upd.pos_y = sat_add(ram_rdata.pos_y, ram_rdata.vel_y);
    upd.life  = ram_rdata.life - 8'd1;
  end

  // Next state and RAM port control.
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = count[AW-1:0];
    ram_wdata  = '0;
    ram_raddr  = idx[AW-1:0];
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (items.valid) begin
          if (cmd_t'(items.cmd) == CMD_CREATE && count < CW'(TABLE_DEPTH)) begin
            ram_we    = 1'b1;
            ram_wdata = '{kind: items.ptype, pos_y: items.pos_y, pos_x: items.pos_x,
                          vel_y: items.vel_y, vel_x: items.vel_x,
                          start: items.life, life: items.life};
          end
          if (cmd_t'(items.cmd) == CMD_TICK && count != '0) begin
            state_next = ST_TK_RD;
          end
        end
      end
      ST_TK_RD: state_next = ST_TK_MOD;
      ST_TK_MOD: begin
        if (ram_rdata.life > 8'd1) begin
          ram_we    = 1'b1;
          ram_waddr = wr_idx[AW-1:0];
          ram_wdata = upd;
        end
        if (idx + CW'(1) == count) begin
          if (wr_idx == '0 && ram_rdata.life <= 8'd1) begin
            state_next = ST_IDLE;
          end else begin
            state_next = ST_RP_RD;
          end
        end else begin
          state_next = ST_TK_RD;
        end
      end
      ST_RP_RD: state_next = ST_RP_MUL;
      ST_RP_MUL: state_next = ST_RP_START;
      ST_RP_START: begin
        div_start  = 1'b1;
        state_next = ST_RP_DIV;
      end
      ST_RP_DIV: begin
        if (div_done) begin
          state_next = ST_RP_OUT;
        end
      end
      ST_RP_OUT: begin
        if (results.ready) begin
          state_next = (idx + CW'(1) == count) ? ST_IDLE : ST_RP_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Counters and the report datapath.
  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      idx    <= '0;
      wr_idx <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          idx    <= '0;
          wr_idx <= '0;
          if (items.valid) begin
            if (cmd_t'(items.cmd) == CMD_CREATE && count < CW'(TABLE_DEPTH)) begin
              count <= count + CW'(1);
            end else if (cmd_t'(items.cmd) == CMD_CLEAR) begin
              count <= '0;
            end
          end
        end
        ST_TK_MOD: begin
          if (ram_rdata.life > 8'd1) begin
            wr_idx <= wr_idx + CW'(1);
          end
          if (idx + CW'(1) == count) begin
            count <= wr_idx + CW'(ram_rdata.life > 8'd1);
            idx   <= '0;
          end else begin
            idx <= idx + CW'(1);
          end
        end
        ST_RP_MUL: begin
          out_kind <= ram_rdata.kind;
          out_px   <= to_pixel(ram_rdata.pos_x);
          out_py   <= to_pixel(ram_rdata.pos_y);
          neg_x    <= ram_rdata.vel_x[15];
          neg_y    <= ram_rdata.vel_y[15];
          prod_x   <= {8'd0, mag16(ram_rdata.vel_x)} * {16'd0, ram_rdata.life};
          prod_y   <= {8'd0, mag16(ram_rdata.vel_y)} * {16'd0, ram_rdata.life};
          den      <= DEN_W'({ram_rdata.start, 6'd0});
        end
        ST_RP_DIV: begin
          if (div_done) begin
            if (out_kind == KIND_LINE) begin
              out_dx <= neg_x ? (10'd0 - q_x) : q_x;
              out_dy <= neg_y ? (10'd0 - q_y) : q_y;
            end else begin
              out_dx <= '0;
              out_dy <= '0;
            end
          end
        end
        ST_RP_OUT: begin
          if (results.ready) begin
            idx <= idx + CW'(1);
          end
        end
        default: ;
      endcase
    end
  end

  assign items.ready     = (state == ST_IDLE);
  assign results.valid   = (state == ST_RP_OUT);
  assign results.kind    = out_kind;
  assign results.pixel_x = out_px;
  assign results.pixel_y = out_py;
  assign results.line_dx = out_dx;
  assign results.line_dy = out_dy;
  assign results.last    = (idx + CW'(1) == count);

endmodule
